>>> sv/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Shared constants, types and the half-sine table of the microstep driver.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam int TABLE_STEPS = 128;
  localparam int PWM_PERIOD  = 4000;

  localparam int IDX_W    = $clog2(TABLE_STEPS);
  localparam int DIV_W    = 8;
  localparam int DUTY_W   = 12;
  localparam int SCALE_W  = 4;
  localparam int TICK_W   = 8;

  localparam int SCALE_MAX   = 10;
  localparam int SCALE_RESET = 4;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam int DIV10_RECIP = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int FACTOR_W    = 20;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0] IDX_TOP     = IDX_W'(TABLE_STEPS - 1);
  localparam logic [IDX_W-1:0] IDX_A_RESET = IDX_W'((TABLE_STEPS / 2 + 5) % TABLE_STEPS);

  typedef enum logic [2:0] {
    PH_INIT = 3'd0,
    PH_A    = 3'd1,
    PH_B    = 3'd2,
    PH_C    = 3'd3,
    PH_D    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_STOP = 2'd1,
    CMD_STEP = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             load;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic             dir_a;
    logic             dir_b;
  } cmd_t;

  typedef logic [DUTY_W-1:0] rom_t [TABLE_STEPS];

  localparam logic [63:0] Q60_ONE = 64'd1 << 60;
  localparam logic [63:0] Q60_PI  = 64'd3622009729038561421;
  localparam logic [63:0] LO32    = 64'h0000_0000_FFFF_FFFF;

  localparam logic [63:0] Q60_PI_STEP = Q60_PI / TABLE_STEPS;
  localparam logic [63:0] Q60_PI_REM  = Q60_PI % TABLE_STEPS;

  // Taylor denominators (k - 1) * k for k = 3, 5, ..., 29
  localparam int TAYLOR_TERMS = 14;
  localparam logic [63:0] TAYLOR_DEN [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
  };

  // Q4.60 product, truncated
  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid, lo;
    ah  = a >> 32;
    al  = a & LO32;
    bh  = b >> 32;
    bl  = b & LO32;
    mid = ah * bl + al * bh;
    lo  = al * bl;
    return ((ah * bh) << 4) + ((mid + (lo >> 32)) >> 28);
  endfunction

  function automatic logic [DUTY_W-1:0] rom_entry(int unsigned i);
    logic [63:0] n, m, s, x, x2, term, mm, r;
    logic        sub;
    n   = 64'(TABLE_STEPS);
    m   = (2 * 64'(i) > n) ? n - 64'(i) : 64'(i);
    s   = '0;
    sub = 1'b1;
    if (m == 0) begin
      return '0;
    end
    if (2 * m == n) begin
      s = Q60_ONE;
    end else begin
      x    = Q60_PI_STEP * m + (Q60_PI_REM * m) / TABLE_STEPS;
      x2   = q60_mul(x, x);
      term = x;
      s    = x;
      for (int j = 0; j < TAYLOR_TERMS; j++) begin
        term = q60_mul(term, x2) / TAYLOR_DEN[j];
        if (sub) begin
          s = s - term;
        end else begin
          s = s + term;
        end
        sub = !sub;
      end
    end
    mm = 64'(PWM_PERIOD - 1);
    r  = (mm * (s >> 32) + ((mm * (s & LO32)) >> 32)) >> 28;
    return r[DUTY_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TABLE_STEPS; i++) begin
      r[i] = rom_entry(i);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

>>> sv/smd_if.sv
// ----------------------------------------------------------------------------
// smd channel interfaces
// Valid/ready channels for tick requests, results and the scale register.
// ----------------------------------------------------------------------------
interface smd_in_if;
  logic                       valid;
  logic                       ready;
  logic [smd_pkg::DIV_W-1:0]  step_divisor;

  modport source (output valid, output step_divisor, input ready);
  modport sink   (input valid, input step_divisor, output ready);
endinterface

interface smd_out_if;
  logic                       valid;
  logic                       ready;
  logic [smd_pkg::DUTY_W-1:0] duty_a;
  logic [smd_pkg::DUTY_W-1:0] duty_b;
  logic                       dir_a;
  logic                       dir_b;
  logic                       stepped;

  modport source (output valid, output duty_a, output duty_b, output dir_a,
                  output dir_b, output stepped, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input dir_a,
                  input dir_b, input stepped, output ready);
endinterface

interface smd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [smd_pkg::SCALE_W-1:0] amplitude_scale;

  modport source (output valid, output amplitude_scale, input ready);
  modport sink   (input valid, input amplitude_scale, output ready);
endinterface

>>> sv/smd_front.sv
// ----------------------------------------------------------------------------
// smd_front
// Tick counter, phase machine and table indices; issues one command per tick.
// ----------------------------------------------------------------------------
module smd_front (
  input  logic            clk,
  input  logic            rst_n,
  smd_in_if.sink          in_chan,
  output smd_pkg::cmd_t   cmd,
  output logic            cmd_valid,
  input  logic            cmd_ready
);

  logic [smd_pkg::TICK_W-1:0] tick_r, tick_nxt, tick_inc;
  smd_pkg::phase_t            phase_r, phase_nxt;
  logic [smd_pkg::IDX_W-1:0]  idx_a_r, idx_a_nxt;
  logic [smd_pkg::IDX_W-1:0]  idx_b_r, idx_b_nxt;
  logic                       dir_a_r, dir_a_nxt;
  logic                       dir_b_r, dir_b_nxt;
  logic                       accept;

  assign in_chan.ready = cmd_ready;
  assign cmd_valid     = in_chan.valid;
  assign accept        = in_chan.valid && cmd_ready;
  assign tick_inc      = tick_r + smd_pkg::TICK_W'(1);

  always_comb begin
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    idx_a_nxt = idx_a_r;
    idx_b_nxt = idx_b_r;
    dir_a_nxt = dir_a_r;
    dir_b_nxt = dir_b_r;
    cmd.kind  = smd_pkg::CMD_HOLD;
    cmd.load  = 1'b0;
    cmd.idx_a = idx_a_r;
    cmd.idx_b = idx_b_r;
    if (in_chan.step_divisor == '0) begin
      cmd.kind = smd_pkg::CMD_STOP;
    end else if (tick_inc >= smd_pkg::TICK_W'(in_chan.step_divisor)) begin
      tick_nxt = '0;
      cmd.kind = smd_pkg::CMD_STEP;
      unique case (phase_r)
        smd_pkg::PH_A: begin
          cmd.load = 1'b1;
          if (idx_a_r == '0) dir_a_nxt = 1'b1;
          if (idx_b_r == smd_pkg::IDX_TOP) phase_nxt = smd_pkg::PH_B;
        end
        smd_pkg::PH_B: begin
          cmd.load = 1'b1;
          if (idx_b_r == '0) dir_b_nxt = 1'b1;
          if (idx_a_r == smd_pkg::IDX_TOP) phase_nxt = smd_pkg::PH_C;
        end
        smd_pkg::PH_C: begin
          cmd.load = 1'b1;
          if (idx_a_r == '0) dir_a_nxt = 1'b0;
          if (idx_b_r == smd_pkg::IDX_TOP) phase_nxt = smd_pkg::PH_D;
        end
        smd_pkg::PH_D: begin
          cmd.load = 1'b1;
          if (idx_b_r == '0) dir_b_nxt = 1'b0;
          if (idx_a_r == smd_pkg::IDX_TOP) phase_nxt = smd_pkg::PH_A;
        end
        default: begin
          phase_nxt = smd_pkg::PH_B;
        end
      endcase
      idx_a_nxt = (idx_a_r == smd_pkg::IDX_TOP) ? '0 : idx_a_r + smd_pkg::IDX_W'(1);
      idx_b_nxt = (idx_b_r == smd_pkg::IDX_TOP) ? '0 : idx_b_r + smd_pkg::IDX_W'(1);
    end else begin
      tick_nxt = tick_inc;
    end
    cmd.dir_a = dir_a_nxt;
    cmd.dir_b = dir_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      phase_r <= smd_pkg::PH_B;
      idx_a_r <= smd_pkg::IDX_A_RESET;
      idx_b_r <= '0;
      dir_a_r <= 1'b0;
      dir_b_r <= 1'b0;
    end else if (accept) begin
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      idx_a_r <= idx_a_nxt;
      idx_b_r <= idx_b_nxt;
      dir_a_r <= dir_a_nxt;
      dir_b_r <= dir_b_nxt;
    end
  end

endmodule

>>> sv/smd_queue.sv
// ----------------------------------------------------------------------------
// smd_queue
// Short command FIFO between front and back.
// ----------------------------------------------------------------------------
module smd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  smd_pkg::cmd_t   push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output smd_pkg::cmd_t   pop_data
);

  smd_pkg::cmd_t               mem [smd_pkg::QUEUE_DEPTH];
  logic [smd_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [smd_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        push, pop;

  assign push_ready = (count_r != smd_pkg::QCNT_W'(smd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + smd_pkg::QCNT_W'(1);
    if (pop && !push) count_nxt = count_r - smd_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == smd_pkg::QPTR_W'(smd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + smd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == smd_pkg::QPTR_W'(smd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + smd_pkg::QPTR_W'(1);
      end
    end
  end

endmodule

>>> sv/smd_back.sv
// ----------------------------------------------------------------------------
// smd_back
// Scale register, sine lookup, duty scaling and the result register.
// ----------------------------------------------------------------------------
module smd_back (
  input  logic            clk,
  input  logic            rst_n,
  smd_cfg_if.sink         cfg_chan,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  smd_pkg::cmd_t   cmd,
  smd_out_if.source       out_chan
);

  localparam int PROD_W = smd_pkg::DUTY_W + smd_pkg::FACTOR_W;

  logic [smd_pkg::FACTOR_W-1:0] factor_r, factor_nxt;
  logic [smd_pkg::SCALE_W-1:0]  scale_clamped;
  logic [smd_pkg::DUTY_W-1:0]   rom_a, rom_b;
  logic [PROD_W-1:0]            prod_a, prod_b;
  logic [smd_pkg::DUTY_W-1:0]   duty_a_r, duty_a_nxt;
  logic [smd_pkg::DUTY_W-1:0]   duty_b_r, duty_b_nxt;
  logic                         dir_a_r, dir_b_r, stepped_r, valid_r;
  logic                         pop;

  assign cfg_chan.ready = 1'b1;
  assign scale_clamped  = (cfg_chan.amplitude_scale > smd_pkg::SCALE_W'(smd_pkg::SCALE_MAX)) ?
                          smd_pkg::SCALE_W'(smd_pkg::SCALE_MAX) : cfg_chan.amplitude_scale;
  // scale * 52429, so duty = rom * factor >> 19 = scale * rom / 10
  assign factor_nxt = smd_pkg::FACTOR_W'(scale_clamped) *
                      smd_pkg::FACTOR_W'(smd_pkg::DIV10_RECIP);

  assign rom_a  = smd_pkg::SINE_ROM[cmd.idx_a];
  assign rom_b  = smd_pkg::SINE_ROM[cmd.idx_b];
  assign prod_a = PROD_W'(rom_a) * PROD_W'(factor_r);
  assign prod_b = PROD_W'(rom_b) * PROD_W'(factor_r);

  assign pop       = cmd_valid && (!valid_r || out_chan.ready);
  assign cmd_ready = !valid_r || out_chan.ready;

  always_comb begin
    duty_a_nxt = duty_a_r;
    duty_b_nxt = duty_b_r;
    unique case (cmd.kind)
      smd_pkg::CMD_STOP: begin
        duty_a_nxt = '0;
        duty_b_nxt = '0;
      end
      smd_pkg::CMD_STEP: begin
        if (cmd.load) begin
          duty_a_nxt = prod_a[smd_pkg::DIV10_SHIFT +: smd_pkg::DUTY_W];
          duty_b_nxt = prod_b[smd_pkg::DIV10_SHIFT +: smd_pkg::DUTY_W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r  <= smd_pkg::FACTOR_W'(smd_pkg::SCALE_RESET * smd_pkg::DIV10_RECIP);
      duty_a_r  <= '0;
      duty_b_r  <= '0;
      dir_a_r   <= 1'b0;
      dir_b_r   <= 1'b0;
      stepped_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        factor_r <= factor_nxt;
      end
      if (pop) begin
        valid_r   <= 1'b1;
        duty_a_r  <= duty_a_nxt;
        duty_b_r  <= duty_b_nxt;
        dir_a_r   <= cmd.dir_a;
        dir_b_r   <= cmd.dir_b;
        stepped_r <= (cmd.kind == smd_pkg::CMD_STEP);
      end else if (out_chan.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid   = valid_r;
  assign out_chan.duty_a  = duty_a_r;
  assign out_chan.duty_b  = duty_b_r;
  assign out_chan.dir_a   = dir_a_r;
  assign out_chan.dir_b   = dir_b_r;
  assign out_chan.stepped = stepped_r;

endmodule

>>> sv/sine_microstep_phase_driver_unit.sv
// ----------------------------------------------------------------------------
// sine_microstep_phase_driver_unit
// Two-winding sine microstep driver: tick requests in, PWM duties out.
// ----------------------------------------------------------------------------
// in_chan carries one tick request with its step divisor; a divisor of zero
// stops the motor and zeroes both duties. Every tick gives exactly one result
// on out_chan: both duty compare values, both direction levels and a flag
// that is set when the tick made a microstep. cfg_chan writes the amplitude
// scale (tenths of full sine, 11..15 act as 10); it is always ready and
// should only be written while no tick is in flight.
// Timing: the tick counter, phase machine and indices update in the accept
// cycle, which also writes the command into the queue; the sine lookup and
// scaling happen when the command leaves the queue, and the result register
// then holds the result and offers it on out_chan.
// Throughput: one tick per cycle while the receiver keeps up.
// A stalled receiver first fills the result register, then the two-entry
// command queue, after which in_chan.ready drops.
// Reset: phase B, index A at mid-table plus five, index B at zero, tick
// count, directions and duties zero, scale 4. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sine_microstep_phase_driver_unit (
  input  logic       clk,
  input  logic       rst_n,
  smd_in_if.sink     in_chan,
  smd_cfg_if.sink    cfg_chan,
  smd_out_if.source  out_chan
);

  smd_pkg::cmd_t q_in, q_out;
  logic          q_in_valid, q_in_ready;
  logic          q_out_valid, q_out_ready;

  smd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd       (q_in),
    .cmd_valid (q_in_valid),
    .cmd_ready (q_in_ready)
  );

  smd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out)
  );

  smd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_chan  (cfg_chan),
    .cmd_valid (q_out_valid),
    .cmd_ready (q_out_ready),
    .cmd       (q_out),
    .out_chan  (out_chan)
  );

`ifndef NO_ASSERTIONS
  a_stop_class: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |->
      ((in_chan.step_divisor == '0) == (q_in.kind == smd_pkg::CMD_STOP)))
    else $error("zero divisor not classified as stop");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !(q_out_valid && q_out_ready))
    else $error("queue popped while result stalled");

  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (q_out_valid && q_out_ready) |=> out_chan.valid)
    else $error("popped command gave no result");
`endif

endmodule
